>>> hw/rtl/ipru_pkg.sv
// Shared types and constants for the integer pixel replication upscaler.
package ipru_pkg;

    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 30;
    localparam int DIM_W   = 13;
    localparam int SCALE_W = 4;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_SRC_WIDTH    = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_SCALE_FACTOR = 2'd2;

    localparam logic [DIM_W-1:0]   RST_SRC_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0]   RST_SRC_HEIGHT   = 13'd480;
    localparam logic [SCALE_W-1:0] RST_SCALE_FACTOR = 4'd2;

    typedef struct packed {
        logic [DIM_W-1:0]   src_width;
        logic [DIM_W-1:0]   src_height;
        logic [SCALE_W-1:0] scale_factor;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic load;
        logic base;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic block_last;
    } sts_t;

endpackage

>>> hw/rtl/ipru_ifs.sv
// Stream interfaces for source pixel items and upscaled copy items.
interface ipru_pix_if;
    logic                        valid;
    logic                        ready;
    logic [ipru_pkg::COLOR_W-1:0] pix_red;
    logic [ipru_pkg::COLOR_W-1:0] pix_green;
    logic [ipru_pkg::COLOR_W-1:0] pix_blue;

    modport source (output valid, output pix_red, output pix_green, output pix_blue,
                    input ready);
    modport sink (input valid, input pix_red, input pix_green, input pix_blue,
                  output ready);
endinterface

interface ipru_blk_if;
    logic                        valid;
    logic                        ready;
    logic [ipru_pkg::ADDR_W-1:0]  dest_addr;
    logic [ipru_pkg::COLOR_W-1:0] out_red;
    logic [ipru_pkg::COLOR_W-1:0] out_green;
    logic [ipru_pkg::COLOR_W-1:0] out_blue;
    logic                        block_last;

    modport source (output valid, output dest_addr, output out_red, output out_green,
                    output out_blue, output block_last, input ready);
    modport sink (input valid, input dest_addr, input out_red, input out_green,
                  input out_blue, input block_last, output ready);
endinterface

>>> hw/rtl/ipru_cfg.sv
// APB configuration registers of the upscaler.
module ipru_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipru_pkg::PADDR_W-1:0]  paddr,
    input  logic [ipru_pkg::PDATA_W-1:0]  pwdata,
    output logic [ipru_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output ipru_pkg::cfg_t                cfg
);

    logic [ipru_pkg::DIM_W-1:0]   src_width_reg;
    logic [ipru_pkg::DIM_W-1:0]   src_height_reg;
    logic [ipru_pkg::SCALE_W-1:0] scale_factor_reg;
    logic                         wr_en;
    logic [1:0]                   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg    <= ipru_pkg::RST_SRC_WIDTH;
            src_height_reg   <= ipru_pkg::RST_SRC_HEIGHT;
            scale_factor_reg <= ipru_pkg::RST_SCALE_FACTOR;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ipru_pkg::REG_SRC_WIDTH:    src_width_reg    <= pwdata[ipru_pkg::DIM_W-1:0];
                ipru_pkg::REG_SRC_HEIGHT:   src_height_reg   <= pwdata[ipru_pkg::DIM_W-1:0];
                ipru_pkg::REG_SCALE_FACTOR: scale_factor_reg <= pwdata[ipru_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ipru_pkg::REG_SRC_WIDTH:    prdata = ipru_pkg::PDATA_W'(src_width_reg);
            ipru_pkg::REG_SRC_HEIGHT:   prdata = ipru_pkg::PDATA_W'(src_height_reg);
            ipru_pkg::REG_SCALE_FACTOR: prdata = ipru_pkg::PDATA_W'(scale_factor_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.src_width    = src_width_reg;
    assign cfg.src_height   = src_height_reg;
    assign cfg.scale_factor = scale_factor_reg;

endmodule

>>> hw/rtl/ipru_ctrl.sv
// Controller state machine: accept, address setup and copy emission.
module ipru_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  ipru_pkg::sts_t sts,
    output ipru_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BASE = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                cmd.base   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.step = 1'b1;
                    if (sts.block_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/ipru_dp.sv
// Datapath: source counters, address products and copy address stepping.
module ipru_dp #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_SCALE  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ipru_pkg::cfg_t                cfg,
    input  ipru_pkg::pix_t                pix_in,
    input  ipru_pkg::cmd_t                cmd,
    output ipru_pkg::sts_t                sts,
    output logic [ipru_pkg::ADDR_W-1:0]   dest_addr,
    output ipru_pkg::pix_t                pix_out
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int S_W    = $clog2(MAX_SCALE + 1);
    localparam int IJ_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
    localparam int Y_W    = ROW_W + S_W;
    localparam int X_W    = COL_W + S_W;
    localparam int DW_W   = W_W + S_W;
    localparam int PROD_W = Y_W + DW_W;
    localparam int AW     = ipru_pkg::ADDR_W;

    logic [W_W-1:0]    w_eff;
    logic [H_W-1:0]    h_eff;
    logic [S_W-1:0]    s_eff;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [IJ_W-1:0]   i_reg;
    logic [IJ_W-1:0]   i_next;
    logic [IJ_W-1:0]   j_reg;
    logic [IJ_W-1:0]   j_next;
    logic [Y_W-1:0]    y0_reg;
    logic [X_W-1:0]    x0_reg;
    logic [DW_W-1:0]   dw_reg;
    logic [AW-1:0]     base_reg;
    logic [AW-1:0]     base_next;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     addr_next;
    logic [PROD_W-1:0] prod;
    logic              col_wrap;
    logic              row_wrap;
    logic              row_end;
    ipru_pkg::pix_t    pix_reg;

    always_comb
    begin
        if (cfg.src_width == '0)
            w_eff = W_W'(1);
        else if (32'(cfg.src_width) > 32'(MAX_WIDTH))
            w_eff = W_W'(MAX_WIDTH);
        else
            w_eff = W_W'(cfg.src_width);

        if (cfg.src_height == '0)
            h_eff = H_W'(1);
        else if (32'(cfg.src_height) > 32'(MAX_HEIGHT))
            h_eff = H_W'(MAX_HEIGHT);
        else
            h_eff = H_W'(cfg.src_height);

        if (cfg.scale_factor == '0)
            s_eff = S_W'(1);
        else if (32'(cfg.scale_factor) > 32'(MAX_SCALE))
            s_eff = S_W'(MAX_SCALE);
        else
            s_eff = S_W'(cfg.scale_factor);
    end

    assign row_end        = (S_W'(j_reg) == s_eff - S_W'(1));
    assign sts.block_last = row_end && (S_W'(i_reg) == s_eff - S_W'(1));

    assign col_wrap = (32'(col_reg) + 32'd1 >= 32'(w_eff));
    assign row_wrap = (32'(row_reg) + 32'd1 >= 32'(h_eff));
    assign prod     = PROD_W'(y0_reg) * PROD_W'(dw_reg);

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        base_next = base_reg;
        addr_next = addr_reg;
        if (cmd.base)
        begin
            base_next = AW'(prod) + AW'(x0_reg);
            addr_next = AW'(prod) + AW'(x0_reg);
            i_next    = '0;
            j_next    = '0;
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        else if (cmd.step)
        begin
            if (row_end)
            begin
                j_next    = '0;
                i_next    = i_reg + IJ_W'(1);
                base_next = base_reg + AW'(1);
                addr_next = base_reg + AW'(1);
            end
            else
            begin
                j_next    = j_reg + IJ_W'(1);
                addr_next = addr_reg + AW'(dw_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            i_reg   <= '0;
            j_reg   <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg <= pix_in;
            y0_reg  <= Y_W'(row_reg) * Y_W'(s_eff);
            x0_reg  <= X_W'(col_reg) * X_W'(s_eff);
            dw_reg  <= DW_W'(w_eff) * DW_W'(s_eff);
        end
        base_reg <= base_next;
        addr_reg <= addr_next;
    end

    assign dest_addr = addr_reg;
    assign pix_out   = pix_reg;

endmodule

>>> hw/rtl/integer_pixel_replication_upscaler.sv
// Top level of the integer pixel replication upscaler.
// A taken pixel goes through the address setup state before its first copy is offered.
// Copies leave one per cycle while blk.ready is high; a stall holds the current copy.
// A new pixel is taken only after the last copy of the previous pixel is accepted.
// Reset: rst_n asynchronous; counters to zero, registers to 640 x 480 at scale 2.
module integer_pixel_replication_upscaler #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_SCALE  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    ipru_pix_if.sink                     pix,
    ipru_blk_if.source                   blk,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipru_pkg::PADDR_W-1:0] paddr,
    input  logic [ipru_pkg::PDATA_W-1:0] pwdata,
    output logic [ipru_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    ipru_pkg::cfg_t cfg;
    ipru_pkg::cmd_t cmd;
    ipru_pkg::sts_t sts;
    ipru_pkg::pix_t pix_in;
    ipru_pkg::pix_t pix_out;

    assign pix_in.red   = pix.pix_red;
    assign pix_in.green = pix.pix_green;
    assign pix_in.blue  = pix.pix_blue;

    ipru_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipru_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .out_valid (blk.valid),
        .out_ready (blk.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ipru_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SCALE  (MAX_SCALE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_in    (pix_in),
        .cmd       (cmd),
        .sts       (sts),
        .dest_addr (blk.dest_addr),
        .pix_out   (pix_out)
    );

    assign blk.out_red    = pix_out.red;
    assign blk.out_green  = pix_out.green;
    assign blk.out_blue   = pix_out.blue;
    assign blk.block_last = sts.block_last;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        pix.ready |-> !blk.valid)
        else $error("pixel taken while copies pending");

    a_setup_gap: assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.ready |=> !blk.valid && !pix.ready)
        else $error("no setup cycle after pixel item");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        blk.valid && blk.ready && blk.block_last |=> pix.ready)
        else $error("block did not return to idle after last copy");

    a_more_copies: assert property (@(posedge clk) disable iff (!rst_n)
        blk.valid && blk.ready && !blk.block_last |=> blk.valid)
        else $error("copy sequence cut short");

endmodule
